>>> src/mqte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqte_pkg - shared types and constants for the multi-queue transfer engine
// Command and result payloads, operation and status codes, and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package mqte_pkg;

    // default geometry, overridable on the top level
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_NUM_QUEUES  = 3;

    // a list reports at most this many entries
    localparam int MAX_RESULTS = 32;
    localparam int LEFT_W      = $clog2(MAX_RESULTS + 1);

    // operation codes
    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_MOVE  = 2'd1,
        MODE_SERVE = 2'd2,
        MODE_LIST  = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // input beat
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  source_queue;
        logic [1:0]  target_queue;
        logic [7:0]  entry_byte;
    } t_cmd;

    // result beat
    typedef struct packed {
        t_status     status;
        logic [7:0]  listed_byte;
        logic        byte_valid;
        logic        last_of_run;
    } t_res;

    // which kind of result the datapath builds this cycle
    typedef enum logic [2:0] {
        EM_NONE  = 3'd0,
        EM_EMPTY = 3'd1,
        EM_SERVE = 3'd2,
        EM_PUSH  = 3'd3,
        EM_LIST  = 3'd4
    } t_emit;

    // controller -> datapath
    typedef struct packed {
        logic  load;       // latch the accepted command
        logic  sel_dst;    // queue select: target instead of source
        logic  pop;        // read source head, advance head, drop count
        logic  list_init;  // read source head, arm the list walk
        logic  list_step;  // read next list entry
        logic  cap_byte;   // keep the fetched byte for a move
        logic  push;       // write byte at target tail if not full
        t_emit emit_kind;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_mode mode;       // latched operation
        logic  src_empty;  // selected queue empty or out of range
        logic  left_one;   // list walk on its final entry
    } t_dp_stat;

endpackage
`default_nettype wire

>>> src/multi_queue_transfer_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_transfer_engine_top - byte FIFOs in shared storage
// Add, move, serve and list operations over NUM_QUEUES circular byte queues
// of QUEUE_DEPTH entries each, held in one store.
//
//   channel   ports                        handshake
//   --------  ---------------------------  -----------------------------------
//   command   i_cmd                        taken when start & !busy
//   result    o_res                        one beat per cycle of o_res_valid
//
// States after accept: add S_DST; serve S_SRC, S_FETCH; move S_SRC, S_FETCH,
//   S_DST; list S_SRC, then S_LIST per entry reported (at most 32);
//   the store is read once per cycle with registered data.
// busy stays high until the last beat is registered; a new command can be
// taken while that beat is on the result ports.
// Reset (synchronous, active low) empties every queue; the store needs no
// clearing pass. The receiver cannot stall: every result beat is final.
// ----------------------------------------------------------------------------
module multi_queue_transfer_engine_top #(
    parameter int QUEUE_DEPTH = mqte_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_QUEUES  = mqte_pkg::DEF_NUM_QUEUES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire mqte_pkg::t_cmd  i_cmd,
    output logic                 o_res_valid,
    output mqte_pkg::t_res       o_res
);
    import mqte_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // sequencer
    mqte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_cmd.mode),
        .i_stat  (stat),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    // storage and pointers
    mqte_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

>>> src/mqte_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqte_ctrl - operation sequencer
// One-hot state machine that steps each command through source lookup,
// store fetch, target push or list walk, and drives the datapath.
// ----------------------------------------------------------------------------
module mqte_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire mqte_pkg::t_mode   i_mode,
    input  wire mqte_pkg::t_dp_stat i_stat,
    output logic                   busy,
    output mqte_pkg::t_dp_cmd      o_ctl
);
    import mqte_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SRC   = 5'b00010,
        S_FETCH = 5'b00100,
        S_DST   = 5'b01000,
        S_LIST  = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd ctl;

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        ctl           = '0;
        ctl.emit_kind = EM_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    ctl.load = 1'b1;
                    n_state  = (i_mode == MODE_ADD) ? S_DST : S_SRC;
                end
            end
            S_SRC: begin
                if (i_stat.src_empty) begin
                    ctl.emit_kind = EM_EMPTY;
                    n_state       = S_IDLE;
                end else if (i_stat.mode == MODE_LIST) begin
                    ctl.list_init = 1'b1;
                    n_state       = S_LIST;
                end else begin
                    ctl.pop = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                ctl.cap_byte = 1'b1;
                if (i_stat.mode == MODE_SERVE) begin
                    ctl.emit_kind = EM_SERVE;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_DST;
                end
            end
            S_DST: begin
                ctl.sel_dst   = 1'b1;
                ctl.push      = 1'b1;
                ctl.emit_kind = EM_PUSH;
                n_state       = S_IDLE;
            end
            S_LIST: begin
                ctl.list_step = 1'b1;
                ctl.emit_kind = EM_LIST;
                if (i_stat.left_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_ctl = ctl;

    // an accepted beat always makes the engine busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // list walk ends right after its final entry
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) && i_stat.left_one |=> (r_state == S_IDLE))
        else $error("list walk overran its final entry");

    // store fetch only follows a source pop
    a_fetch_after_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> ($past(r_state) == S_SRC))
        else $error("fetch entered without source lookup");

endmodule
`default_nettype wire

>>> src/mqte_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqte_dp - queue storage and pointer datapath
// Shared byte store, per-queue head pointers and entry counts, list walk
// counters and the registered result beat.
// ----------------------------------------------------------------------------
module mqte_dp #(
    parameter int QUEUE_DEPTH = mqte_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_QUEUES  = mqte_pkg::DEF_NUM_QUEUES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mqte_pkg::t_cmd     i_cmd,
    input  wire mqte_pkg::t_dp_cmd  i_ctl,
    output mqte_pkg::t_dp_stat      o_stat,
    output logic                    o_res_valid,
    output mqte_pkg::t_res          o_res
);
    import mqte_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int QW = $clog2(NUM_QUEUES);
    localparam int MD = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);

    t_cmd              r_cmd;
    logic [7:0]        r_byte;
    logic [PW-1:0]     r_head  [NUM_QUEUES];
    logic [CW-1:0]     r_count [NUM_QUEUES];
    logic [PW-1:0]     r_pos;
    logic [LEFT_W-1:0] r_left;
    logic [7:0]        r_mem   [MD];
    logic [7:0]        r_rdata;
    logic              r_res_valid;
    t_res              r_res;
    logic              n_res_valid;
    t_res              n_res;

    logic [1:0]        sel_field;
    logic [QW-1:0]     sel_q;
    logic              sel_ok;
    logic [PW-1:0]     sel_head;
    logic [CW-1:0]     sel_cnt;
    logic              sel_empty;
    logic              sel_full;
    logic [PW-1:0]     head_inc;
    logic [PW-1:0]     pos_inc;
    logic [SW-1:0]     tail_sum;
    logic [PW-1:0]     tail;
    logic [AW-1:0]     base;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [LEFT_W-1:0] list_n;
    logic              is_move;

    // queue select: one queue looked at per cycle
    assign sel_field = i_ctl.sel_dst ? r_cmd.target_queue : r_cmd.source_queue;
    assign sel_q     = QW'(sel_field);
    assign sel_ok    = (32'(sel_field) < 32'(NUM_QUEUES));
    assign sel_head  = sel_ok ? r_head[sel_q]  : '0;
    assign sel_cnt   = sel_ok ? r_count[sel_q] : '0;
    assign sel_empty = !sel_ok || (sel_cnt == '0);
    assign sel_full  = !sel_ok || (sel_cnt == CW'(QUEUE_DEPTH));

    // circular pointer arithmetic
    assign head_inc = (sel_head == PW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PW'(1);
    assign pos_inc  = (r_pos == PW'(QUEUE_DEPTH - 1)) ? '0 : r_pos + PW'(1);
    assign tail_sum = SW'(sel_head) + SW'(sel_cnt);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                      PW'(tail_sum - SW'(QUEUE_DEPTH)) : PW'(tail_sum);

    // store addresses
    assign base    = AW'(sel_q) * AW'(QUEUE_DEPTH);
    assign rd_addr = base + AW'(i_ctl.list_step ? r_pos : sel_head);
    assign wr_addr = base + AW'(tail);

    // list length, capped at the report limit
    assign list_n = (32'(sel_cnt) > 32'(MAX_RESULTS)) ?
                    LEFT_W'(MAX_RESULTS) : LEFT_W'(sel_cnt);

    assign is_move = (r_cmd.mode == MODE_MOVE);

    // shared byte store, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !sel_full) begin
            r_mem[wr_addr] <= r_byte;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // latched command and working byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_byte <= i_cmd.entry_byte;
        end else if (i_ctl.cap_byte) begin
            r_byte <= r_rdata;
        end
    end

    // head pointers and entry counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q]  <= '0;
                r_count[q] <= '0;
            end
        end else if (i_ctl.pop && sel_ok) begin
            r_head[sel_q]  <= head_inc;
            r_count[sel_q] <= sel_cnt - CW'(1);
        end else if (i_ctl.push && !sel_full) begin
            r_count[sel_q] <= sel_cnt + CW'(1);
        end
    end

    // list walk position and remaining count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_ctl.list_init) begin
            r_left <= list_n;
        end else if (i_ctl.list_step) begin
            r_left <= r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.list_init) begin
            r_pos <= head_inc;
        end else if (i_ctl.list_step) begin
            r_pos <= pos_inc;
        end
    end

    // result beat build
    always_comb begin
        n_res_valid       = 1'b1;
        n_res.status      = STAT_DONE;
        n_res.listed_byte = '0;
        n_res.byte_valid  = 1'b0;
        n_res.last_of_run = 1'b1;
        case (i_ctl.emit_kind)
            EM_EMPTY: begin
                n_res.status = STAT_EMPTY;
            end
            EM_SERVE: begin
                n_res.listed_byte = r_rdata;
                n_res.byte_valid  = 1'b1;
            end
            EM_PUSH: begin
                n_res.status      = sel_full ? STAT_FULL : STAT_DONE;
                n_res.listed_byte = is_move ? r_byte : 8'd0;
                n_res.byte_valid  = is_move;
            end
            EM_LIST: begin
                n_res.listed_byte = r_rdata;
                n_res.byte_valid  = 1'b1;
                n_res.last_of_run = (r_left == LEFT_W'(1));
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    // result register: strobe cleared by reset, payload loaded only with a valid beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_stat      = '{mode:      r_cmd.mode,
                           src_empty: sel_empty,
                           left_one:  (r_left == LEFT_W'(1))};

    // list walk never steps past its length
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.list_step |-> (r_left != '0))
        else $error("list step with no entries left");

    // a list beat that is not last is followed by another beat
    a_list_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_of_run |=> o_res_valid)
        else $error("list stream broke before its last beat");

    // entry count stays within the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sel_ok |-> (r_count[sel_q] <= CW'(QUEUE_DEPTH)))
        else $error("entry count above queue depth");

endmodule
`default_nettype wire

>>> dv/tb_multi_queue_transfer_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_queue_transfer_engine_top - self-checking bench for the queue engine
// Commands go in through the start/busy handshake. A shadow copy of the three
// byte queues predicts each result beat, and every strobed beat is checked in
// order against it. Directed tests cover empty and out-of-range queues and
// every operation, a fill test drives one queue past full, and weighted
// random traffic runs the rest with random idle gaps.
// ----------------------------------------------------------------------------
module tb_multi_queue_transfer_engine_top;
    import mqte_pkg::*;

    localparam int QDEPTH   = DEF_QUEUE_DEPTH;
    localparam int NQ       = DEF_NUM_QUEUES;
    localparam int BAD_Q    = 3;   // queue index past the last queue
    localparam int TAIL_CYC = 40;  // longer than the longest list run

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_res_valid;
    t_res o_res;

    // shadow queues
    logic [7:0] shadow_store [NQ][QDEPTH];
    int         shadow_head  [NQ];
    int         shadow_count [NQ];

    t_res expected_beats [$];
    int   fail_count;
    int   burst_left;  // items left in a stretch without idle gaps

    multi_queue_transfer_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_res make_beat(t_status st, logic [7:0] b, logic v, logic last);
        t_res r;
        r.status      = st;
        r.listed_byte = b;
        r.byte_valid  = v;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic string beat_str(t_res r);
        return $sformatf("status=%0d byte=%02h valid=%0b last=%0b",
                         r.status, r.listed_byte, r.byte_valid, r.last_of_run);
    endfunction

    // push onto a shadow queue; 0 when the queue is full or out of range
    function automatic bit shadow_push(int q, logic [7:0] b);
        if (q >= NQ || shadow_count[q] >= QDEPTH)
            return 1'b0;
        shadow_store[q][(shadow_head[q] + shadow_count[q]) % QDEPTH] = b;
        shadow_count[q]++;
        return 1'b1;
    endfunction

    function automatic logic [7:0] shadow_pop(int q);
        logic [7:0] b;
        b = shadow_store[q][shadow_head[q]];
        shadow_head[q] = (shadow_head[q] + 1) % QDEPTH;
        shadow_count[q]--;
        return b;
    endfunction

    // update the shadow queues and queue up the beats this command yields
    task automatic predict_command(input t_cmd c);
        int         src;
        int         dst;
        int         n;
        logic [7:0] b;
        src = int'(c.source_queue);
        dst = int'(c.target_queue);
        if (c.mode == MODE_ADD) begin
            if (shadow_push(dst, c.entry_byte))
                expected_beats.push_back(make_beat(STAT_DONE, 8'h00, 1'b0, 1'b1));
            else
                expected_beats.push_back(make_beat(STAT_FULL, 8'h00, 1'b0, 1'b1));
        end else if (src >= NQ || shadow_count[src] == 0) begin
            expected_beats.push_back(make_beat(STAT_EMPTY, 8'h00, 1'b0, 1'b1));
        end else if (c.mode == MODE_MOVE) begin
            // pop first, so a move onto the same full queue rotates it
            b = shadow_pop(src);
            if (shadow_push(dst, b))
                expected_beats.push_back(make_beat(STAT_DONE, b, 1'b1, 1'b1));
            else
                expected_beats.push_back(make_beat(STAT_FULL, b, 1'b1, 1'b1));
        end else if (c.mode == MODE_SERVE) begin
            b = shadow_pop(src);
            expected_beats.push_back(make_beat(STAT_DONE, b, 1'b1, 1'b1));
        end else begin
            n = (shadow_count[src] > MAX_RESULTS) ? MAX_RESULTS : shadow_count[src];
            for (int i = 0; i < n; i++) begin
                b = shadow_store[src][(shadow_head[src] + i) % QDEPTH];
                expected_beats.push_back(make_beat(STAT_DONE, b, 1'b1, i == n - 1));
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat: %s", $time, beat_str(o_res));
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_res.status !== want.status || o_res.listed_byte !== want.listed_byte ||
                    o_res.byte_valid !== want.byte_valid ||
                    o_res.last_of_run !== want.last_of_run) begin
                    $display("%0t: result mismatch: expected %s, actual %s",
                             $time, beat_str(want), beat_str(o_res));
                    fail_count++;
                end
            end
        end
    end

    // one command beat: hold start until taken, then an optional idle gap
    task automatic send_cmd(input t_cmd c);
        int gap;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_command(c);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(5, 15);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 8);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input t_mode m, input int src, input int dst, input int b);
        t_cmd c;
        c.mode         = m;
        c.source_queue = src[1:0];
        c.target_queue = dst[1:0];
        c.entry_byte   = b[7:0];
        send_cmd(c);
    endtask

    // hold off new commands until every expected beat has come back
    task automatic wait_drain();
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int pick_queue();
        return ($urandom_range(0, 9) == 0) ? BAD_Q : $urandom_range(0, NQ - 1);
    endfunction

    // empty queues and out-of-range indexes
    task automatic test_empty_queues();
        send_op(MODE_LIST,  0, 0, 8'h00);
        send_op(MODE_SERVE, 1, 0, 8'h00);
        send_op(MODE_MOVE,  2, 0, 8'h00);
        send_op(MODE_SERVE, BAD_Q, 0, 8'hFF);
        send_op(MODE_LIST,  BAD_Q, 1, 8'h00);
        send_op(MODE_MOVE,  BAD_Q, 0, 8'h00);
        send_op(MODE_ADD,   0, BAD_Q, 8'hFF);
        wait_drain();
    endtask

    // every operation on short queues, byte extremes, self-move, drop on bad target
    task automatic test_basic_ops();
        send_op(MODE_ADD,   0, 0, 8'h00);
        send_op(MODE_ADD,   0, 0, 8'hFF);
        send_op(MODE_ADD,   0, 0, 8'h5A);
        send_op(MODE_ADD,   0, 1, 8'hA5);
        send_op(MODE_LIST,  0, 0, 8'h00);
        send_op(MODE_MOVE,  0, 1, 8'h00);
        send_op(MODE_MOVE,  1, 1, 8'h00);
        send_op(MODE_LIST,  1, 0, 8'h00);
        send_op(MODE_SERVE, 1, 0, 8'h00);
        send_op(MODE_LIST,  1, 0, 8'h00);
        send_op(MODE_MOVE,  0, BAD_Q, 8'h00);
        send_op(MODE_LIST,  0, 0, 8'h00);
        send_op(MODE_SERVE, 0, 0, 8'h00);
        send_op(MODE_LIST,  0, 0, 8'h00);
        wait_drain();
    endtask

    // fill one queue past full, rotate it, list all of it, move into it
    task automatic test_full_queue();
        for (int i = 0; i < QDEPTH + 2; i++)
            send_op(MODE_ADD, 0, 2, $urandom_range(0, 255));
        send_op(MODE_MOVE,  2, 2, 8'h00);
        send_op(MODE_LIST,  2, 0, 8'h00);
        send_op(MODE_MOVE,  1, 2, 8'h00);
        send_op(MODE_SERVE, 2, 0, 8'h00);
        send_op(MODE_LIST,  2, 0, 8'h00);
        wait_drain();
    endtask

    // weighted random traffic; add_pct steers queues toward full or empty
    task automatic test_random_traffic(input int n_items, input int add_pct);
        int    r;
        int    rest;
        t_mode m;
        rest = 100 - add_pct;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                m = MODE_ADD;
            else if (r < add_pct + (rest * 45) / 100)
                m = MODE_MOVE;
            else if (r < add_pct + (rest * 75) / 100)
                m = MODE_SERVE;
            else
                m = MODE_LIST;
            send_op(m, pick_queue(), pick_queue(), $urandom_range(0, 255));
        end
    endtask

    initial begin
        fail_count = 0;
        burst_left = 0;
        for (int q = 0; q < NQ; q++) begin
            shadow_head[q]  = 0;
            shadow_count[q] = 0;
        end
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_queues();
        test_basic_ops();
        test_full_queue();
        test_random_traffic(50, 65);
        wait_drain();
        test_random_traffic(50, 30);
        wait_drain();
        repeat (TAIL_CYC) @(posedge i_clk);

        if (expected_beats.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
